@@ rtl/dithered_triangle_fill_defines.svh @@
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef DITHERED_TRIANGLE_FILL_DEFINES_SVH
`define DITHERED_TRIANGLE_FILL_DEFINES_SVH

// Same-cycle implication.
`define DTF_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication.
`define DTF_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ rtl/dtf_pkg.sv @@
`timescale 1ns / 1ps

package dtf_pkg;

    localparam int SCREEN_ROWS    = 240;
    localparam int SCREEN_COLUMNS = 400;
    localparam int FRAME_DEPTH    = 3840;
    localparam int ONE_Q16        = 65536;

    localparam int FB_ADDR_W = $clog2(FRAME_DEPTH);
    localparam int ROW_W     = $clog2(SCREEN_ROWS);
    localparam int STRIDE_W  = 5;
    localparam int BASE_W    = ROW_W + STRIDE_W;
    localparam int LIN_W     = BASE_W + 1;
    localparam int COL_W     = $clog2(SCREEN_COLUMNS + 1);
    localparam int WCOL_W    = COL_W - 5;
    localparam int ROWNUM_W  = 18;
    localparam int DIV_NUM_W = 49;
    localparam int DIV_CNT_W = 6;

    typedef logic signed [ROWNUM_W-1:0] row_t;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET  = 5'd13;
    localparam logic signed [31:0]  ROW_LIMIT_Q16 = 32'(SCREEN_ROWS * ONE_Q16);
    localparam row_t                ROW_CLIP      = row_t'(SCREEN_ROWS);
    localparam logic signed [16:0]  COL_CLIP      = 17'(SCREEN_COLUMNS);

    localparam logic KIND_FILL = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic        start;
        logic [32:0] dx;
        logic [32:0] dy;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] slope;
    } div_rsp_t;

    typedef struct packed {
        logic                 span_start;
        logic                 read_start;
        logic [BASE_W-1:0]    base;
        logic [WCOL_W-1:0]    col_first;
        logic [WCOL_W-1:0]    col_edge;
        logic [WCOL_W-1:0]    col_end;
        logic [4:0]           sbit;
        logic [4:0]           ebit;
        logic [31:0]          color;
        logic [FB_ADDR_W-1:0] read_addr;
    } rmw_req_t;

    typedef struct packed {
        logic        busy;
        logic        rd_done;
        logic [31:0] rd_data;
    } rmw_status_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef enum logic [1:0] {
        RMW_CLEAR,
        RMW_IDLE,
        RMW_SPAN,
        RMW_READ
    } rmw_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SETUP,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_HALF,
        ST_SKIP_L,
        ST_SKIP_M,
        ST_SKIP_R,
        ST_ROW,
        ST_ROW_WAIT,
        ST_DONE
    } top_state_t;

endpackage

@@ rtl/dtf_if.sv @@
`timescale 1ns / 1ps

interface dtf_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] c_x;
    logic [31:0] c_y;
    logic [63:0] dither_rows;
    logic [11:0] read_address;

    modport source (output valid, kind, a_x, a_y, b_x, b_y, c_x, c_y, dither_rows,
                    read_address, input ready);
    modport sink (input valid, kind, a_x, a_y, b_x, b_y, c_x, c_y, dither_rows,
                  read_address, output ready);
endinterface

interface dtf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  first_row;
    logic [7:0]  end_row;
    logic [31:0] read_data;

    modport source (output valid, first_row, end_row, read_data, input ready);
    modport sink (input valid, first_row, end_row, read_data, output ready);
endinterface

@@ rtl/dtf_ram.sv @@
`timescale 1ns / 1ps

module dtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 3840
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/dtf_slope_div.sv @@
`timescale 1ns / 1ps
`include "dithered_triangle_fill_defines.svh"

module dtf_slope_div import dtf_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    div_state_t state_reg, state_next;

    logic [DIV_NUM_W-1:0] quo_reg;
    logic [32:0]          rem_reg;
    logic [32:0]          den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 neg_reg;
    logic                 small_reg;
    logic [31:0]          small_val_reg;

    logic                 small_dy;
    logic [32:0]          mag;
    logic [33:0]          trial;
    logic                 fits;
    logic [31:0]          sat_quo;
    logic [31:0]          sat_dx;

    function automatic logic [31:0] sat33(logic [32:0] v);
        if (!v[32] && v[31])
        begin
            return 32'h7fffffff;
        end
        else if (v[32] && !v[31])
        begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    assign small_dy = $signed(req.dy) < $signed(33'(ONE_Q16));
    assign mag      = req.dx[32] ? 33'(-req.dx) : req.dx;
    assign trial    = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign sat_dx   = sat33(req.dx);

    always_comb
    begin
        if (!neg_reg)
        begin
            sat_quo = (quo_reg > DIV_NUM_W'(32'h7fffffff)) ? 32'h7fffffff : quo_reg[31:0];
        end
        else
        begin
            sat_quo = (quo_reg > DIV_NUM_W'(32'h80000000)) ? 32'h80000000
                                                           : 32'(-quo_reg[31:0]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    state_next = small_dy ? DIV_DONE : DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp.done  = (state_reg == DIV_DONE);
        rsp.slope = small_reg ? small_val_reg : sat_quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && req.start)
        begin
            small_reg     <= small_dy;
            small_val_reg <= sat_dx;
            neg_reg       <= req.dx[32];
            quo_reg       <= {mag, 16'b0};
            rem_reg       <= '0;
            den_reg       <= req.dy;
            cnt_reg       <= DIV_CNT_W'(DIV_NUM_W);
        end
        else if (state_reg == DIV_RUN)
        begin
            rem_reg <= fits ? 33'(trial - {1'b0, den_reg}) : trial[32:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    `DTF_ASSERT_IMP(a_div_start_idle, req.start, state_reg == DIV_IDLE,
                    "slope division started while one is in progress")

endmodule

@@ rtl/dtf_span_rmw.sv @@
`timescale 1ns / 1ps
`include "dithered_triangle_fill_defines.svh"

module dtf_span_rmw import dtf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  rmw_req_t    req,
    output rmw_status_t status
);

    rmw_state_t state_reg, state_next;

    logic [FB_ADDR_W-1:0] clr_cnt_reg;
    logic [WCOL_W-1:0]    w_reg;
    logic [BASE_W-1:0]    base_reg;
    logic [WCOL_W-1:0]    col_first_reg;
    logic [WCOL_W-1:0]    col_edge_reg;
    logic [WCOL_W-1:0]    col_end_reg;
    logic [4:0]           sbit_reg;
    logic [4:0]           ebit_reg;
    logic [31:0]          color_reg;
    logic                 s1_valid_reg;
    logic [FB_ADDR_W-1:0] s1_addr_reg;
    logic [31:0]          s1_mask_reg;
    logic                 rd_range_reg;

    logic                 ram_we;
    logic [FB_ADDR_W-1:0] ram_waddr;
    logic [31:0]          ram_wdata;
    logic                 ram_re;
    logic [FB_ADDR_W-1:0] ram_raddr;
    logic [31:0]          ram_rdata;

    logic [LIN_W-1:0]     lin;
    logic                 lin_ok;
    logic                 rd_ok;
    logic [31:0]          smask;
    logic [31:0]          emask;
    logic [31:0]          mask;

    function automatic logic [31:0] byte_swap(logic [31:0] n);
        return {n[7:0], n[15:8], n[23:16], n[31:24]};
    endfunction

    dtf_ram #(
        .WIDTH (32),
        .DEPTH (FRAME_DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign lin    = LIN_W'(base_reg) + LIN_W'(w_reg);
    assign lin_ok = lin < LIN_W'(FRAME_DEPTH);
    assign rd_ok  = {1'b0, req.read_addr} < (FB_ADDR_W + 1)'(FRAME_DEPTH);
    assign smask  = byte_swap(32'hffffffff >> sbit_reg);
    assign emask  = byte_swap(~(32'hffffffff >> ebit_reg));
    assign mask   = ((w_reg == col_first_reg) ? smask : 32'hffffffff)
                  & ((w_reg == col_edge_reg) ? emask : 32'hffffffff);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            RMW_CLEAR:
            begin
                if (clr_cnt_reg == FB_ADDR_W'(FRAME_DEPTH - 1))
                begin
                    state_next = RMW_IDLE;
                end
            end
            RMW_IDLE:
            begin
                if (req.span_start)
                begin
                    state_next = RMW_SPAN;
                end
                else if (req.read_start)
                begin
                    state_next = RMW_READ;
                end
            end
            RMW_SPAN:
            begin
                if (w_reg == WCOL_W'(col_end_reg - 1'b1))
                begin
                    state_next = RMW_IDLE;
                end
            end
            RMW_READ:
            begin
                state_next = RMW_IDLE;
            end
            default:
            begin
                state_next = RMW_IDLE;
            end
        endcase
    end

    // Each write of a span lands in the cycle after its read; the next span starts
    // only after the last write, so no read can meet a pending write.
    always_comb
    begin
        ram_we    = s1_valid_reg;
        ram_waddr = s1_addr_reg;
        ram_wdata = (ram_rdata & ~s1_mask_reg) | (color_reg & s1_mask_reg);
        ram_re    = 1'b0;
        ram_raddr = lin[FB_ADDR_W-1:0];
        unique case (state_reg)
            RMW_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            RMW_IDLE:
            begin
                ram_re    = req.read_start && rd_ok;
                ram_raddr = req.read_addr;
            end
            RMW_SPAN:
            begin
                ram_re = lin_ok;
            end
            RMW_READ:
            begin
                ram_re = 1'b0;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
        status.busy    = (state_reg != RMW_IDLE) || s1_valid_reg;
        status.rd_done = (state_reg == RMW_READ);
        status.rd_data = rd_range_reg ? ram_rdata : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= RMW_CLEAR;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= (state_reg == RMW_SPAN) && lin_ok;
            if (state_reg == RMW_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == RMW_IDLE && req.span_start)
        begin
            w_reg         <= req.col_first;
            base_reg      <= req.base;
            col_first_reg <= req.col_first;
            col_edge_reg  <= req.col_edge;
            col_end_reg   <= req.col_end;
            sbit_reg      <= req.sbit;
            ebit_reg      <= req.ebit;
            color_reg     <= req.color;
        end
        else if (state_reg == RMW_SPAN)
        begin
            w_reg       <= w_reg + 1'b1;
            s1_addr_reg <= lin[FB_ADDR_W-1:0];
            s1_mask_reg <= mask;
        end
        if (state_reg == RMW_IDLE && req.read_start)
        begin
            rd_range_reg <= rd_ok;
        end
    end

    `DTF_ASSERT_IMP(a_no_rw_overlap, ram_we && ram_re, ram_waddr != ram_raddr,
                    "frame read and write hit the same word in one cycle")
    `DTF_ASSERT_IMP(a_start_when_idle, req.span_start || req.read_start, !status.busy,
                    "span or read started while the frame store is busy")
    `DTF_ASSERT_NEXT(a_read_answers, req.read_start, status.rd_done,
                     "frame read did not answer in the next cycle")

endmodule

@@ rtl/dithered_triangle_fill.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake      Payload
// items     in         valid/ready    kind, a_x..c_y, dither_rows, read_address
// results   out        valid/ready    first_row, end_row, read_data
// cfg       in         cfg_we         cfg_wdata (row_stride_words)
//
// After reset a clearing pass writes zero to all 3840 frame words, one per
// cycle; no item is taken during the clearing pass.
// A fill runs the three slope divisions in turn (49 steps each, skipped when dy
// is below one row; one quotient bit a cycle), then per half the setup and the
// left, middle and right skip steps, then the rows; each drawn row is written
// by the one-word-a-cycle read-modify-write of the frame memory.
// The result waits in an output register; the next item is taken meanwhile.

module dithered_triangle_fill import dtf_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [STRIDE_W-1:0] cfg_wdata,
    dtf_in_if.sink              items,
    dtf_out_if.source           results
);

    top_state_t state_reg, state_next;

    logic [STRIDE_W-1:0] stride_reg;
    logic signed [31:0]  x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic [63:0]         pattern_reg;
    row_t                r1_reg, r2_reg, endy_reg;
    logic [1:0]          div_idx_reg;
    logic [31:0]         sb_reg, sc_reg, dm_reg;
    logic                lt_reg;
    logic                half_reg;
    logic [31:0]         xl_reg, xr_reg, dl_reg, dr_reg;
    logic [16:0]         skip_n_reg;
    logic [31:0]         prod_reg;
    row_t                y_reg, yend_reg;
    logic [7:0]          res_first_reg, res_end_reg;
    logic [31:0]         res_data_reg;
    logic                out_valid_reg;
    logic [7:0]          out_first_reg, out_end_reg;
    logic [31:0]         out_data_reg;

    logic                accept;
    logic signed [31:0]  vx [3];
    logic signed [31:0]  vy [3];
    logic [1:0]          o1, o2, o3;
    row_t                r1_c, r2_c, r3_c, endy_c;
    logic                reject;
    div_req_t            div_req;
    div_rsp_t            div_rsp;
    rmw_req_t            rmw_req;
    rmw_status_t         rmw_status;
    logic                lt_c;
    row_t                r2_clip, y_src, yend_src, n_src;
    logic [31:0]         slope_sel;
    logic [48:0]         skip_prod;
    logic signed [16:0]  xa_s, xb_s, xa_c, xb_c;
    logic                span_off;
    logic                span_go;
    logic                row_left;
    logic [WCOL_W-1:0]   col_first, col_edge, col_end;
    logic                out_free;

    function automatic row_t q16_trunc(logic signed [31:0] v);
        row_t t;
        t = {{(ROWNUM_W - 16){v[31]}}, v[31:16]};
        if (v[31] && v[15:0] != 16'd0)
        begin
            t = t + 1'b1;
        end
        return t;
    endfunction

    function automatic logic [32:0] ext_diff(logic [31:0] p, logic [31:0] q);
        return {p[31], p} - {q[31], q};
    endfunction

    assign accept   = items.valid && items.ready;
    assign out_free = !out_valid_reg || results.ready;

    // Vertex order by y; ties follow a fixed three-way compare.
    always_comb
    begin
        vx[0] = items.a_x;
        vy[0] = items.a_y;
        vx[1] = items.b_x;
        vy[1] = items.b_y;
        vx[2] = items.c_x;
        vy[2] = items.c_y;
        if (vy[0] <= vy[1] && vy[0] < vy[2])
        begin
            o1 = 2'd0;
            o2 = (vy[2] < vy[1]) ? 2'd2 : 2'd1;
            o3 = (vy[2] < vy[1]) ? 2'd1 : 2'd2;
        end
        else if (vy[1] < vy[0] && vy[1] < vy[2])
        begin
            o1 = 2'd1;
            o2 = (vy[2] < vy[0]) ? 2'd2 : 2'd0;
            o3 = (vy[2] < vy[0]) ? 2'd0 : 2'd2;
        end
        else
        begin
            o1 = 2'd2;
            o2 = (vy[0] < vy[1]) ? 2'd0 : 2'd1;
            o3 = (vy[0] < vy[1]) ? 2'd1 : 2'd0;
        end
    end

    assign r1_c   = q16_trunc(y1_reg);
    assign r2_c   = q16_trunc(y2_reg);
    assign r3_c   = q16_trunc(y3_reg);
    assign endy_c = (r3_c > ROW_CLIP) ? ROW_CLIP : r3_c;
    assign reject = (y1_reg > ROW_LIMIT_Q16) || (endy_c < 0);

    always_comb
    begin
        div_req.start = (state_reg == ST_DIV_START);
        unique case (div_idx_reg)
            2'd0:
            begin
                div_req.dx = ext_diff(x2_reg, x1_reg);
                div_req.dy = ext_diff(y2_reg, y1_reg);
            end
            2'd1:
            begin
                div_req.dx = ext_diff(x3_reg, x1_reg);
                div_req.dy = ext_diff(y3_reg, y1_reg);
            end
            default:
            begin
                div_req.dx = ext_diff(x3_reg, x2_reg);
                div_req.dy = ext_diff(y3_reg, y2_reg);
            end
        endcase
    end

    dtf_slope_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Half setup: rows above the screen are skipped with one multiply per edge.
    assign lt_c    = $signed(sb_reg) < $signed(sc_reg);
    assign r2_clip = (r2_reg > ROW_CLIP) ? ROW_CLIP : r2_reg;
    always_comb
    begin
        if (!half_reg)
        begin
            y_src    = r1_reg;
            yend_src = r2_clip;
        end
        else
        begin
            y_src    = r2_reg;
            yend_src = endy_reg;
        end
        if (yend_src < 0)
        begin
            n_src = yend_src - y_src;
        end
        else if (y_src < 0)
        begin
            n_src = -y_src;
        end
        else
        begin
            n_src = '0;
        end
    end

    assign slope_sel = (state_reg == ST_SKIP_L) ? dl_reg : dr_reg;
    assign skip_prod = skip_n_reg * slope_sel;

    // Span of the current row, clipped to the screen.
    assign row_left = y_reg < yend_reg;
    assign xa_s     = {xl_reg[31], xl_reg[31:16]};
    assign xb_s     = {xr_reg[31], xr_reg[31:16]} + 17'sd1;
    assign span_off = (xb_s < 0) || (xa_s >= COL_CLIP);
    assign xa_c     = (xa_s < 0) ? 17'sd0 : xa_s;
    assign xb_c     = (xb_s > COL_CLIP) ? COL_CLIP : xb_s;
    assign col_first = xa_c[COL_W-1:5];
    assign col_edge  = xb_c[COL_W-1:5];
    assign col_end   = col_edge + WCOL_W'(xb_c[4:0] != 5'd0);
    assign span_go   = !span_off && (xa_c <= xb_c) && (col_first < col_end);

    always_comb
    begin
        rmw_req.span_start = (state_reg == ST_ROW) && row_left && span_go;
        rmw_req.read_start = accept && (items.kind == KIND_READ);
        rmw_req.base       = BASE_W'(y_reg[ROW_W-1:0] * stride_reg);
        rmw_req.col_first  = col_first;
        rmw_req.col_edge   = col_edge;
        rmw_req.col_end    = col_end;
        rmw_req.sbit       = xa_c[4:0];
        rmw_req.ebit       = xb_c[4:0];
        rmw_req.color      = {4{pattern_reg[{y_reg[2:0], 3'b000} +: 8]}};
        rmw_req.read_addr  = items.read_address;
    end

    dtf_span_rmw u_rmw (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (rmw_req),
        .status (rmw_status)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (items.kind == KIND_READ) ? ST_READ : ST_SETUP;
                end
            end
            ST_READ:
            begin
                if (rmw_status.rd_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SETUP:
            begin
                state_next = reject ? ST_DONE : ST_DIV_START;
            end
            ST_DIV_START:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (div_idx_reg == 2'd2) ? ST_HALF : ST_DIV_START;
                end
            end
            ST_HALF:
            begin
                state_next = ST_SKIP_L;
            end
            ST_SKIP_L:
            begin
                state_next = ST_SKIP_M;
            end
            ST_SKIP_M:
            begin
                state_next = ST_SKIP_R;
            end
            ST_SKIP_R:
            begin
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                if (row_left)
                begin
                    state_next = span_go ? ST_ROW_WAIT : ST_ROW;
                end
                else
                begin
                    state_next = half_reg ? ST_DONE : ST_HALF;
                end
            end
            ST_ROW_WAIT:
            begin
                if (!rmw_status.busy)
                begin
                    state_next = ST_ROW;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        items.ready       = (state_reg == ST_IDLE) && !rmw_status.busy;
        results.valid     = out_valid_reg;
        results.first_row = out_first_reg;
        results.end_row   = out_end_reg;
        results.read_data = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stride_reg    <= STRIDE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                stride_reg <= cfg_wdata;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x1_reg       <= vx[o1];
                    y1_reg       <= vy[o1];
                    x2_reg       <= vx[o2];
                    y2_reg       <= vy[o2];
                    x3_reg       <= vx[o3];
                    y3_reg       <= vy[o3];
                    pattern_reg  <= items.dither_rows;
                    res_data_reg <= '0;
                end
            end
            ST_READ:
            begin
                res_first_reg <= '0;
                res_end_reg   <= '0;
                res_data_reg  <= rmw_status.rd_data;
            end
            ST_SETUP:
            begin
                r1_reg      <= r1_c;
                r2_reg      <= r2_c;
                endy_reg    <= endy_c;
                div_idx_reg <= 2'd0;
                half_reg    <= 1'b0;
                if (reject)
                begin
                    res_first_reg <= '0;
                    res_end_reg   <= '0;
                end
                else
                begin
                    res_first_reg <= (r1_c < 0) ? 8'd0 : r1_c[7:0];
                    res_end_reg   <= endy_c[7:0];
                end
            end
            ST_DIV_START:
            begin
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    unique case (div_idx_reg)
                        2'd0:    sb_reg <= div_rsp.slope;
                        2'd1:    sc_reg <= div_rsp.slope;
                        default: dm_reg <= div_rsp.slope;
                    endcase
                    div_idx_reg <= div_idx_reg + 1'b1;
                end
            end
            ST_HALF:
            begin
                y_reg      <= (y_src < 0) ? '0 : y_src;
                yend_reg   <= yend_src;
                skip_n_reg <= n_src[16:0];
                if (!half_reg)
                begin
                    lt_reg <= lt_c;
                    xl_reg <= x1_reg;
                    xr_reg <= x1_reg;
                    dl_reg <= lt_c ? sb_reg : sc_reg;
                    dr_reg <= lt_c ? sc_reg : sb_reg;
                end
                else if (lt_reg)
                begin
                    xl_reg <= x2_reg;
                    dl_reg <= dm_reg;
                end
                else
                begin
                    xr_reg <= x2_reg;
                    dr_reg <= dm_reg;
                end
            end
            ST_SKIP_L:
            begin
                prod_reg <= skip_prod[31:0];
            end
            ST_SKIP_M:
            begin
                xl_reg   <= xl_reg + prod_reg;
                prod_reg <= skip_prod[31:0];
            end
            ST_SKIP_R:
            begin
                xr_reg <= xr_reg + prod_reg;
            end
            ST_ROW:
            begin
                if (row_left)
                begin
                    xl_reg <= xl_reg + dl_reg;
                    xr_reg <= xr_reg + dr_reg;
                    y_reg  <= y_reg + 1'b1;
                end
                else if (!half_reg)
                begin
                    half_reg <= 1'b1;
                end
            end
            ST_ROW_WAIT:
            begin
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_first_reg <= res_first_reg;
                    out_end_reg   <= res_end_reg;
                    out_data_reg  <= res_data_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

class fill_scoreboard;
    bit [31:0] frame[3840];
    bit [4:0]  stride;
    bit [7:0]  exp_first[$];
    bit [7:0]  exp_end[$];
    bit [31:0] exp_data[$];
    int        errors;
    int        checked;
    int        fills_drawn;

    function new();
        foreach (frame[i]) frame[i] = '0;
        stride = 5'd13;
        errors = 0;
        checked = 0;
        fills_drawn = 0;
    endfunction

    function longint sx(bit [31:0] v);
        return longint'($signed(v));
    endfunction

    function longint floor16(bit [31:0] u);
        longint s;
        s = sx(u);
        return s >= 0 ? s / 65536 : -((-s + 65535) / 65536);
    endfunction

    function bit [31:0] swap_bytes(bit [31:0] n);
        return {n[7:0], n[15:8], n[23:16], n[31:24]};
    endfunction

    function longint slope(longint xa, longint ya, longint xb, longint yb);
        longint dx, dy, r;
        dx = xb - xa;
        dy = yb - ya;
        if (dy < 65536) r = dx;
        else r = (dx * 65536) / dy;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    function void put(longint addr, bit [31:0] mask, bit [31:0] color);
        if (addr >= 0 && addr < 3840)
            frame[addr] = (frame[addr] & ~mask) | (color & mask);
    endfunction

    function void span(longint y, longint xa, longint xb, bit [31:0] color);
        longint base, sb, eb, col, x;
        bit [31:0] sm, em, m;
        if (xb < 0 || xa >= 400) return;
        if (xa < 0) xa = 0;
        if (xb > 400) xb = 400;
        if (xa > xb) return;
        base = y * stride;
        sb = xa % 32;
        eb = xb % 32;
        sm = swap_bytes(32'hffffffff >> sb);
        em = eb > 0 ? swap_bytes(~(32'hffffffff >> eb)) : 32'h0;
        col = xa / 32;
        if (col == xb / 32) begin
            m = 0;
            if (sb > 0 && eb > 0) m = sm & em;
            else if (sb > 0) m = sm;
            else if (eb > 0) m = em;
            put(base + col, m, color);
            return;
        end
        x = xa;
        if (sb > 0) begin
            put(base + col, sm, color);
            col++;
            x += 32 - sb;
        end
        while (x + 32 <= xb) begin
            put(base + col, 32'hffffffff, color);
            col++;
            x += 32;
        end
        if (eb > 0) put(base + col, em, color);
    endfunction

    function void half(longint y, longint endy, ref bit [31:0] xl, input bit [31:0] dl,
                       ref bit [31:0] xr, input bit [31:0] dr, input bit [63:0] pat);
        bit [31:0] n;
        bit [31:0] color;
        if (endy < 0) begin
            n = 32'(endy - y);
            xl = xl + n * dl;
            xr = xr + n * dr;
            return;
        end
        if (y < 0) begin
            n = 32'(-y);
            xl = xl + n * dl;
            xr = xr + n * dr;
            y = 0;
        end
        while (y < endy) begin
            color = {4{pat[8 * (y % 8) +: 8]}};
            span(y, floor16(xl), floor16(xr) + 1, color);
            xl = xl + dl;
            xr = xr + dr;
            y++;
        end
    endfunction

    // Notes an accepted item and queues the result it should produce.
    function void note_item(bit kind, bit [31:0] v[6], bit [63:0] pat, bit [11:0] addr);
        longint vy[3], vx[3], x1, y1, x2, y2, x3, y3, r1, r2, endy, sbv, scv, dl, dr, dm;
        int o1, o2, o3;
        bit [31:0] xl, xr;
        if (kind) begin
            exp_first.push_back(0);
            exp_end.push_back(0);
            exp_data.push_back(addr < 3840 ? frame[addr] : 32'h0);
            return;
        end
        for (int i = 0; i < 3; i++) begin
            vx[i] = sx(v[2 * i]);
            vy[i] = sx(v[2 * i + 1]);
        end
        o1 = 0; o2 = 1; o3 = 2;
        if (vy[0] <= vy[1] && vy[0] < vy[2]) begin
            if (vy[2] < vy[1]) begin o2 = 2; o3 = 1; end
        end
        else if (vy[1] < vy[0] && vy[1] < vy[2]) begin
            o1 = 1;
            if (vy[2] < vy[0]) begin o2 = 2; o3 = 0; end
            else begin o2 = 0; o3 = 2; end
        end
        else begin
            o1 = 2;
            if (vy[0] < vy[1]) begin o2 = 0; o3 = 1; end
            else begin o2 = 1; o3 = 0; end
        end
        x1 = vx[o1]; y1 = vy[o1];
        x2 = vx[o2]; y2 = vy[o2];
        x3 = vx[o3]; y3 = vy[o3];
        r1 = y1 / 65536;
        r2 = y2 / 65536;
        endy = y3 / 65536;
        if (endy > 240) endy = 240;
        exp_data.push_back(0);
        if (y1 > 240 * 65536 || endy < 0) begin
            exp_first.push_back(0);
            exp_end.push_back(0);
            return;
        end
        fills_drawn++;
        xl = 32'(x1);
        xr = xl;
        sbv = slope(x1, y1, x2, y2);
        scv = slope(x1, y1, x3, y3);
        dl = sbv < scv ? sbv : scv;
        dr = sbv < scv ? scv : sbv;
        half(r1, r2 < 240 ? r2 : 240, xl, 32'(dl), xr, 32'(dr), pat);
        dm = slope(x2, y2, x3, y3);
        if (sbv < scv) begin
            xl = 32'(x2);
            half(r2, endy, xl, 32'(dm), xr, 32'(dr), pat);
        end
        else begin
            xr = 32'(x2);
            half(r2, endy, xl, 32'(dl), xr, 32'(dm), pat);
        end
        exp_first.push_back(8'(r1 > 0 ? r1 : 0));
        exp_end.push_back(8'(endy));
    endfunction

    function void check_result(bit [7:0] f, bit [7:0] e, bit [31:0] d);
        bit [7:0] ef, ee;
        bit [31:0] ed;
        if (exp_first.size() == 0) begin
            $display("%0t: unexpected result first_row=%0d end_row=%0d read_data=%h",
                     $time, f, e, d);
            errors++;
            return;
        end
        ef = exp_first.pop_front();
        ee = exp_end.pop_front();
        ed = exp_data.pop_front();
        checked++;
        if (f !== ef) begin
            $display("%0t: first_row expected %0d actual %0d", $time, ef, f);
            errors++;
        end
        if (e !== ee) begin
            $display("%0t: end_row expected %0d actual %0d", $time, ee, e);
            errors++;
        end
        if (d !== ed) begin
            $display("%0t: read_data expected %h actual %h", $time, ed, d);
            errors++;
        end
    endfunction
endclass

module tb;
    import dtf_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [STRIDE_W-1:0] cfg_wdata;
    int                  idle_pct;
    int                  hold_cycles;
    int                  sent;
    int                  reads_sent;

    dtf_in_if  items ();
    dtf_out_if results ();

    fill_scoreboard fb;

    dithered_triangle_fill DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .items     (items.sink),
        .results   (results.source)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #300ms;
        $display("Some tests failed");
        $finish;
    end

    // Checks results and notes items at rising edges; drives ready at falling edges.
    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
            fb.check_result(results.first_row, results.end_row, results.read_data);
        if (rst_n && items.valid && items.ready)
            fb.note_item(items.kind, '{items.a_x, items.a_y, items.b_x, items.b_y,
                         items.c_x, items.c_y}, items.dither_rows, items.read_address);
    end

    initial
    begin
        results.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                results.ready <= 0;
                hold_cycles--;
            end
            else
                results.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Leaves valid high after the accepting edge; at the following falling edge an idle
    // cycle or drain() takes it down, or the next item replaces the payload.
    task automatic send(bit kind, bit [31:0] v[6], bit [63:0] pat, bit [11:0] addr);
        while ($urandom_range(99) < idle_pct)
        begin
            items.valid <= 0;
            @(negedge clk);
        end
        items.valid <= 1;
        items.kind <= kind;
        {items.a_x, items.a_y, items.b_x, items.b_y, items.c_x, items.c_y}
            <= {v[0], v[1], v[2], v[3], v[4], v[5]};
        items.dither_rows <= pat;
        items.read_address <= addr;
        @(posedge clk);
        while (!items.ready) @(posedge clk);
        @(negedge clk);
        sent++;
        if (kind) reads_sent++;
    endtask

    function automatic bit [31:0] q16(int whole, int frac);
        return 32'(whole * 65536 + frac);
    endfunction

    task automatic fill(int ax, int ay, int bx, int by, int cx, int cy, bit [63:0] pat);
        send(KIND_FILL, '{q16(ax, $urandom_range(65535)), q16(ay, $urandom_range(65535)),
             q16(bx, $urandom_range(65535)), q16(by, $urandom_range(65535)),
             q16(cx, $urandom_range(65535)), q16(cy, $urandom_range(65535))}, pat, 0);
    endtask

    task automatic read_word(bit [11:0] addr);
        bit [31:0] z[6];
        foreach (z[i]) z[i] = $urandom;
        send(KIND_READ, z, {$urandom, $urandom}, addr);
    endtask

    // Waits until every expected result is back, then lets the block settle.
    task automatic drain();
        items.valid <= 0;
        while (fb.exp_first.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_stride(bit [4:0] s);
        drain();
        cfg_we <= 1;
        cfg_wdata <= s;
        @(negedge clk);
        cfg_we <= 0;
        fb.stride = s;
    endtask

    task automatic random_item();
        int r;
        bit [31:0] v[6];
        r = $urandom_range(99);
        if (r < 30)
            read_word($urandom_range(99) < 90 ? $urandom_range(3839) : $urandom_range(4095));
        else if (r < 85)
            fill($urandom_range(440) - 20, $urandom_range(60) - 10,
                 $urandom_range(440) - 20, $urandom_range(60) - 10,
                 $urandom_range(440) - 20, $urandom_range(60) - 10, {$urandom, $urandom});
        else if (r < 95)
            fill($urandom_range(500) - 50, $urandom_range(280) - 20,
                 $urandom_range(500) - 50, $urandom_range(280) - 20,
                 $urandom_range(500) - 50, $urandom_range(280) - 20, {$urandom, $urandom});
        else
        begin
            foreach (v[i]) v[i] = $urandom;
            send(KIND_FILL, v, {$urandom, $urandom}, $urandom);
        end
    endtask

    initial
    begin
        bit [31:0] v[6];
        fb = new();
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        idle_pct = 10;
        hold_cycles = 0;
        sent = 0;
        reads_sent = 0;
        items.valid = 0;
        items.kind = 0;
        items.a_x = 0; items.a_y = 0; items.b_x = 0;
        items.b_y = 0; items.c_x = 0; items.c_y = 0;
        items.dither_rows = 0;
        items.read_address = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed part: extremes, rejection, off-screen rows and columns.
        fill(0, 0, 399, 0, 0, 10, 64'hffffffffffffffff);
        read_word(0);
        read_word(12);
        fill(-30, -20, 430, 5, 200, 30, 64'h0123456789abcdef);
        fill(10, 235, 300, 250, 50, 239, 64'haa55aa55aa55aa55);
        fill(0, 241, 10, 260, 5, 300, 64'hff);
        fill(0, -50, 10, -40, 5, -2, 64'hff);
        fill(5, 3, 5, 3, 5, 3, 64'hf0f0f0f0f0f0f0f0);
        fill(-500, 4, -400, 8, -450, 12, 64'hff00ff00ff00ff00);
        fill(600, 4, 700, 8, 650, 12, 64'h1);
        v = '{32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
              32'h00000000, 32'h00000000};
        send(KIND_FILL, v, 64'hffffffffffffffff, 0);
        v = '{32'h80000000, 32'h00000000, 32'h7fffffff, 32'h00008000,
              32'h00000000, 32'h00100000};
        send(KIND_FILL, v, 64'h8000000000000001, 0);
        read_word(13);
        read_word(3839);
        read_word(4095);
        read_word(3840);

        // Stride sweep with a large value where writes run past the store.
        set_stride(5'd16);
        fill(0, 200, 399, 239, 100, 238, 64'h5a5a5a5a5a5a5a5a);
        read_word(3839);
        set_stride(5'd31);
        fill(0, 100, 399, 130, 200, 239, 64'hc3c3c3c3c3c3c3c3);
        read_word(3835);
        set_stride(5'd0);
        fill(0, 2, 100, 6, 30, 9, 64'h0f0f0f0f0f0f0f0f);
        read_word(1);
        set_stride(5'd13);

        // Long receiver hold-off while items keep coming.
        hold_cycles = 3000;
        for (int i = 0; i < 10; i++) random_item();

        for (int ph = 0; ph < 4; ph++)
        begin
            if (ph == 1) set_stride(5'd14);
            if (ph == 2) set_stride(5'd16);
            if (ph == 3) set_stride(5'd13);
            idle_pct = (ph == 2) ? 0 : 10;
            for (int i = 0; i < 70; i++) random_item();
        end
        idle_pct = 10;
        drain();
        $display("Run covered %0d items (%0d reads, %0d drawn fills), %0d results checked.",
                 sent, reads_sent, fb.fills_drawn, fb.checked);
        $display("Strides 0, 13, 14, 16 and 31 were used with random stalls on both sides.");
        if (fb.errors == 0 && fb.exp_first.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dtf_pkg.sv
rtl/dtf_if.sv
rtl/dtf_ram.sv
rtl/dtf_slope_div.sv
rtl/dtf_span_rmw.sv
rtl/dithered_triangle_fill.sv
tb/sv/tb.sv
